/* src/rgbmf_pkg.sv */
// ----------------------------------------------------------------------------
// rgbmf_pkg
// Shared widths, reset values, register indexes and the result record of the
// 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package rgbmf_pkg;

    localparam int PIX_W            = 8;     // one colour channel
    localparam int CFG_W            = 13;    // frame size registers
    localparam int CFG_IDX_W        = 1;     // register index
    localparam int COORD_W          = 12;    // result coordinates
    localparam int Y_W              = 12;    // row counter
    localparam int MIN_SIZE         = 3;
    localparam int MAX_HEIGHT       = 4096;
    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    // Position and end-of-frame mark travelling alongside the median pipe
    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               frame_done;
    } t_meta;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic               frame_done;
    } t_result;

endpackage

/* src/rgbmf_line_ram.sv */
// ----------------------------------------------------------------------------
// rgbmf_line_ram
// Simple dual-port line store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rgbmf_line_ram #(
    parameter int DEPTH  = rgbmf_pkg::DEF_MAX_WIDTH,
    parameter int DATA_W = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/rgbmf_med9.sv */
// ----------------------------------------------------------------------------
// rgbmf_med9
// Three-stage median of nine 8-bit values: sort triples, then max of lows,
// median of mids, min of highs, then median of those three.
// ----------------------------------------------------------------------------
module rgbmf_med9 (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [8:0][rgbmf_pkg::PIX_W-1:0]    i_px,
    output logic [rgbmf_pkg::PIX_W-1:0]         o_med
);

    typedef logic [rgbmf_pkg::PIX_W-1:0] t_pix;

    function automatic t_pix f_min(input t_pix a, input t_pix b);
        return (b < a) ? b : a;
    endfunction

    function automatic t_pix f_max(input t_pix a, input t_pix b);
        return (b < a) ? a : b;
    endfunction

    function automatic t_pix f_med3(input t_pix a, input t_pix b, input t_pix c);
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    t_pix r_lo [3];
    t_pix r_mi [3];
    t_pix r_hi [3];
    t_pix r_lo_max;
    t_pix r_mi_med;
    t_pix r_hi_min;
    t_pix r_med;

    // stage 1: each triple sorted
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < 3; g++) begin
                r_lo[g] <= f_min(f_min(i_px[3*g], i_px[3*g+1]), i_px[3*g+2]);
                r_mi[g] <= f_med3(i_px[3*g], i_px[3*g+1], i_px[3*g+2]);
                r_hi[g] <= f_max(f_max(i_px[3*g], i_px[3*g+1]), i_px[3*g+2]);
            end
        end
    end

    // stage 2 and 3
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_max <= f_max(f_max(r_lo[0], r_lo[1]), r_lo[2]);
            r_mi_med <= f_med3(r_mi[0], r_mi[1], r_mi[2]);
            r_hi_min <= f_min(f_min(r_hi[0], r_hi[1]), r_hi[2]);
            r_med    <= f_med3(r_lo_max, r_mi_med, r_hi_min);
        end
    end

    assign o_med = r_med;

endmodule

/* src/rgbmf_out_skid.sv */
// ----------------------------------------------------------------------------
// rgbmf_out_skid
// Output register with one skid entry; o_full is registered and throttles
// the whole pipe.
// ----------------------------------------------------------------------------
module rgbmf_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rgbmf_pkg::t_result i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output rgbmf_pkg::t_result o_data
);

    logic               r_out_valid;
    logic               r_skid_valid;
    rgbmf_pkg::t_result r_out;
    rgbmf_pkg::t_result r_skid;
    logic               in_take;
    logic               out_free;

    assign in_take  = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_take;
            r_skid_valid <= 1'b0;
        end else if (in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (in_take) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

endmodule

/* src/rgb_median_filter_3x3_top.sv */
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3_top
// 3x3 per-channel median filter over a raster-order RGB pixel stream.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+---------------------------------
//   config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//   pixel in | i_in_valid / o_in_stall    | i_red_in, i_green_in, i_blue_in
//   result   | o_out_valid / i_out_stall  | o_center_x, o_center_y,
//            |                            | o_red_out, o_green_out,
//            |                            | o_blue_out, o_frame_done
//
// Takes one pixel item per clock while o_in_stall is low, as set by the line
// store: one read and one write per cycle. An interior pixel's result passes
// the window shift and median stages into the output register. Reset
// (synchronous) clears counters, window, pipe valids and restores the
// 640x480 frame size. The line stores are not cleared: entries are only used
// once written in the current frame. o_in_stall is the registered skid-full
// flag, so inputs keep flowing while one result waits at the output.
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3_top #(
    parameter int MAX_WIDTH = rgbmf_pkg::DEF_MAX_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rgbmf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rgbmf_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rgbmf_pkg::PIX_W-1:0]       i_red_in,
    input  logic [rgbmf_pkg::PIX_W-1:0]       i_green_in,
    input  logic [rgbmf_pkg::PIX_W-1:0]       i_blue_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rgbmf_pkg::COORD_W-1:0]     o_center_x,
    output logic [rgbmf_pkg::COORD_W-1:0]     o_center_y,
    output logic [rgbmf_pkg::PIX_W-1:0]       o_red_out,
    output logic [rgbmf_pkg::PIX_W-1:0]       o_green_out,
    output logic [rgbmf_pkg::PIX_W-1:0]       o_blue_out,
    output logic                              o_frame_done
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int PW    = rgbmf_pkg::PIX_W;
    localparam int LW    = 3 * PW;            // packed pixel
    localparam int CW    = rgbmf_pkg::CFG_W;
    localparam int YW    = rgbmf_pkg::Y_W;
    localparam int CRD_W = rgbmf_pkg::COORD_W;

    // ---- configuration and position counters -------------------------------
    logic [CW-1:0] r_image_width;
    logic [CW-1:0] r_image_height;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] h_eff;
    logic [XW-1:0] x_cur;
    logic [YW-1:0] y_cur;
    logic [XW-1:0] n_x;
    logic [YW-1:0] n_y;
    logic          x_last;
    logic          y_last;

    // ---- pipe control ----------------------------------------------------
    logic          skid_full;
    logic          en;          // whole pipe advances
    logic          in_acc;

    // sizes clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT
    always_comb begin
        if (r_image_width < CW'(rgbmf_pkg::MIN_SIZE)) begin
            w_eff = CW'(rgbmf_pkg::MIN_SIZE);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = r_image_width;
        end
        if (r_image_height < CW'(rgbmf_pkg::MIN_SIZE)) begin
            h_eff = CW'(rgbmf_pkg::MIN_SIZE);
        end else if (r_image_height > CW'(rgbmf_pkg::MAX_HEIGHT)) begin
            h_eff = CW'(rgbmf_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_image_height;
        end
    end

    always_comb begin
        x_cur   = (32'(r_x) >= 32'(w_eff)) ? '0 : r_x;
        y_cur   = (CW'(r_y) >= h_eff) ? '0 : r_y;
        x_last  = (32'(x_cur) + 32'd1) >= 32'(w_eff);
        y_last  = (CW'(y_cur) + CW'(1)) >= h_eff;
        n_x     = x_last ? '0 : XW'(32'(x_cur) + 32'd1);
        n_y     = y_cur;
        if (x_last) begin
            n_y = y_last ? '0 : y_cur + YW'(1);
        end
    end

    assign en         = !skid_full;
    assign o_in_stall = skid_full;
    assign in_acc     = i_in_valid && en;

    // A register write also restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CW'(rgbmf_pkg::DEF_IMAGE_WIDTH);
            r_image_height <= CW'(rgbmf_pkg::DEF_IMAGE_HEIGHT);
            r_x            <= '0;
            r_y            <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rgbmf_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data;
                end
                rgbmf_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data;
                end
            endcase
            r_x <= '0;
            r_y <= '0;
        end else if (in_acc) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    // ---- stage A: line store read issued --------------------------------
    logic             r_a_valid;
    logic             r_a_emit;
    logic [LW-1:0]    r_a_pix;
    logic [XW-1:0]    r_a_x;
    rgbmf_pkg::t_meta r_a_meta;
    logic [2*LW-1:0]  ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_pix             <= {i_red_in, i_green_in, i_blue_in};
            r_a_x               <= x_cur;
            r_a_emit            <= (32'(x_cur) >= 32'd2) && (y_cur >= YW'(2));
            r_a_meta.center_x   <= CRD_W'(32'(x_cur) - 32'd1);
            r_a_meta.center_y   <= CRD_W'(y_cur - YW'(1));
            r_a_meta.frame_done <= x_last && y_last;
        end
    end

    // entry = {older line, newer line}; write-back shifts newer into older.
    // The same column comes back no sooner than three items later, after
    // the write-back, so no forwarding is needed.
    rgbmf_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * LW)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (x_cur),
        .o_rd_data (ram_rdata),
        .i_wr_en   (en && r_a_valid),
        .i_wr_addr (r_a_x),
        .i_wr_data ({ram_rdata[LW-1:0], r_a_pix})
    );

    // ---- stage B: window shift ------------------------------------------
    logic [LW-1:0]    r_win [9];
    logic             r_b_valid;
    rgbmf_pkg::t_meta r_b_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid && r_a_emit;
            if (r_a_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[3*r]   <= r_win[3*r+1];
                    r_win[3*r+1] <= r_win[3*r+2];
                end
                r_win[2] <= ram_rdata[2*LW-1:LW];
                r_win[5] <= ram_rdata[LW-1:0];
                r_win[8] <= r_a_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_meta <= r_a_meta;
        end
    end

    // ---- median stages (three, one per med9 register) -------------------
    logic [8:0][PW-1:0] red_px;
    logic [8:0][PW-1:0] green_px;
    logic [8:0][PW-1:0] blue_px;
    logic [PW-1:0]      red_med;
    logic [PW-1:0]      green_med;
    logic [PW-1:0]      blue_med;
    logic               r_m_valid [3];
    rgbmf_pkg::t_meta   r_m_meta  [3];
    rgbmf_pkg::t_result res;
    rgbmf_pkg::t_result out_data;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            red_px[k]   = r_win[k][3*PW-1:2*PW];
            green_px[k] = r_win[k][2*PW-1:PW];
            blue_px[k]  = r_win[k][PW-1:0];
        end
    end

    rgbmf_med9 u_med_red (
        .i_clk (i_clk),
        .i_en  (en),
        .i_px  (red_px),
        .o_med (red_med)
    );

    rgbmf_med9 u_med_green (
        .i_clk (i_clk),
        .i_en  (en),
        .i_px  (green_px),
        .o_med (green_med)
    );

    rgbmf_med9 u_med_blue (
        .i_clk (i_clk),
        .i_en  (en),
        .i_px  (blue_px),
        .o_med (blue_med)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 3; s++) begin
                r_m_valid[s] <= 1'b0;
            end
        end else if (en) begin
            r_m_valid[0] <= r_b_valid;
            r_m_valid[1] <= r_m_valid[0];
            r_m_valid[2] <= r_m_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_meta[0] <= r_b_meta;
            r_m_meta[1] <= r_m_meta[0];
            r_m_meta[2] <= r_m_meta[1];
        end
    end

    always_comb begin
        res.center_x   = r_m_meta[2].center_x;
        res.center_y   = r_m_meta[2].center_y;
        res.red        = red_med;
        res.green      = green_med;
        res.blue       = blue_med;
        res.frame_done = r_m_meta[2].frame_done;
    end

    // ---- output register and skid ---------------------------------------
    rgbmf_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_valid[2]),
        .i_data  (res),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_center_x   = out_data.center_x;
    assign o_center_y   = out_data.center_y;
    assign o_red_out    = out_data.red;
    assign o_green_out  = out_data.green;
    assign o_blue_out   = out_data.blue;
    assign o_frame_done = out_data.frame_done;

    // ---- checks ---------------------------------------------------------
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_x) < 32'(w_eff))
        else $error("column counter outside frame width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_y) < h_eff)
        else $error("row counter outside frame height");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

endmodule

/* tb/tb_rgb_median_filter_3x3_top.sv */
// ----------------------------------------------------------------------------
// tb_rgb_median_filter_3x3_top
// Self-checking bench for the 3x3 RGB median filter. A driver feeds pixel
// items from a queue and works out the expected median of every completed
// window as each item is accepted. A monitor compares each result item,
// field by field, with the oldest expectation. Directed frames cover pixel
// extremes, size clamping, restart on a register write and frame wrap.
// One long output hold backs the pipe up into the input; random frames then
// follow under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_rgb_median_filter_3x3_top;

    localparam int PIX_W        = rgbmf_pkg::PIX_W;
    localparam int CFG_W        = rgbmf_pkg::CFG_W;
    localparam int COORD_W      = rgbmf_pkg::COORD_W;
    localparam int MIN_SIZE     = rgbmf_pkg::MIN_SIZE;
    localparam int MAX_HEIGHT   = rgbmf_pkg::MAX_HEIGHT;
    localparam int STORE_DEPTH  = rgbmf_pkg::DEF_MAX_WIDTH;
    localparam int DRAIN_CYCLES = 20;      // pipe drain time, with margin
    localparam int HOLD_CYCLES  = 400;     // long output hold for back-pressure
    localparam int RANDOM_ITEMS = 960;     // random share of the item count
    localparam int NUM_PHASES   = 4;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } t_rgb;

    // How the channel values of a run of pixels are chosen
    typedef enum int {
        PIX_RANDOM,     // anything
        PIX_EXTREME,    // 0, 1, 128, 254, 255 only: many ties
        PIX_NARROW      // tight band, medians sensitive to every sample
    } t_pix_style;

    // ------------------------------------------------------------------------
    // DUT connections; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  cfg_we     = 1'b0;
    rgbmf_pkg::t_cfg_index cfg_index  = rgbmf_pkg::CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]      cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      red_in     = '0;
    logic [PIX_W-1:0]      green_in   = '0;
    logic [PIX_W-1:0]      blue_in    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [COORD_W-1:0]    center_x;
    logic [COORD_W-1:0]    center_y;
    logic [PIX_W-1:0]      red_out;
    logic [PIX_W-1:0]      green_out;
    logic [PIX_W-1:0]      blue_out;
    logic                  frame_done;

    rgb_median_filter_3x3_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_red_in     (red_in),
        .i_green_in   (green_in),
        .i_blue_in    (blue_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_center_x   (center_x),
        .o_center_y   (center_y),
        .o_red_out    (red_out),
        .o_green_out  (green_out),
        .o_blue_out   (blue_out),
        .o_frame_done (frame_done)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_rgb               pix_q[$];     // pixel items waiting for the driver
    rgbmf_pkg::t_result median_q[$];  // expected filter results, oldest first
    int      err_cnt        = 0;
    int      sender_idle    = 0;  // percent of cycles the driver holds back
    int      receiver_stall = 0;  // percent of cycles the output is stalled
    logic    hold_go        = 1'b0;
    int      hold_left      = 0;

    // Predictor copy of the filter: frame size, line stores, window, position
    logic [CFG_W-1:0]   width_reg  = CFG_W'(rgbmf_pkg::DEF_IMAGE_WIDTH);
    logic [CFG_W-1:0]   height_reg = CFG_W'(rgbmf_pkg::DEF_IMAGE_HEIGHT);
    logic [3*PIX_W-1:0] older_row [STORE_DEPTH] = '{default: '0};
    logic [3*PIX_W-1:0] newer_row [STORE_DEPTH] = '{default: '0};
    logic [3*PIX_W-1:0] win [9] = '{default: '0};
    int                 col_pos = 0;
    int                 row_pos = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Register value as the block uses it: out-of-range sizes are clamped
    function automatic int eff_size(logic [CFG_W-1:0] v, int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // Median of one channel over the nine window cells: the value with at
    // most four samples strictly below it and at least five not above it
    function automatic logic [PIX_W-1:0] chan_median(int sh);
        logic [PIX_W-1:0] v [9];
        int below;
        int not_above;
        for (int i = 0; i < 9; i++) v[i] = win[i][sh +: PIX_W];
        for (int i = 0; i < 9; i++) begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < 9; j++) begin
                if (v[j] < v[i]) below++;
                if (v[j] <= v[i]) not_above++;
            end
            if (below <= 4 && not_above >= 5) return v[i];
        end
        return '0;
    endfunction

    // One accepted pixel: shift the window, rotate the line stores and queue
    // the result of the interior pixel whose window it completes, if any
    task automatic take_pixel(t_rgb p);
        int                 w;
        int                 h;
        int                 x;
        int                 y;
        logic [3*PIX_W-1:0] top;
        logic [3*PIX_W-1:0] mid;
        rgbmf_pkg::t_result res;
        w = eff_size(width_reg, STORE_DEPTH);
        h = eff_size(height_reg, MAX_HEIGHT);
        x = (col_pos >= w) ? 0 : col_pos;
        y = (row_pos >= h) ? 0 : row_pos;
        top          = older_row[x];
        mid          = newer_row[x];
        older_row[x] = mid;
        newer_row[x] = p;
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = p;
        if (x >= 2 && y >= 2) begin
            res.center_x   = COORD_W'(x - 1);
            res.center_y   = COORD_W'(y - 1);
            res.red        = chan_median(2*PIX_W);
            res.green      = chan_median(PIX_W);
            res.blue       = chan_median(0);
            res.frame_done = (x == w - 1) && (y == h - 1);
            median_q.push_back(res);
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset: reset asserted from time zero, released once, never again
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Driver: offers the next queued item unless idling; a stalled item is
    // held unchanged. The expectation is built at the edge that accepts it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_pixels
        t_rgb nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) take_pixel({red_in, green_in, blue_in});
            if (!in_valid || !in_stall) begin
                if (pix_q.size() != 0 && $urandom_range(99) >= sender_idle) begin
                    nxt       = pix_q.pop_front();
                    red_in   <= nxt.r;
                    green_in <= nxt.g;
                    blue_in  <= nxt.b;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: random stalls plus a long counted hold on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        out_stall <= hold_go || (hold_left > 1) || ($urandom_range(99) < receiver_stall);
    end

    // ------------------------------------------------------------------------
    // Monitor: each accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch_results
        rgbmf_pkg::t_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (median_q.size() == 0) begin
                $error("unexpected result item at (%0d,%0d)", center_x, center_y);
                err_cnt++;
            end else begin
                want = median_q.pop_front();
                check_field("center_x",   want.center_x,   center_x);
                check_field("center_y",   want.center_y,   center_y);
                check_field("red_out",    want.red,        red_out);
                check_field("green_out",  want.green,      green_out);
                check_field("blue_out",   want.blue,       blue_out);
                check_field("frame_done", want.frame_done, frame_done);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] pick_chan(t_pix_style style);
        logic [PIX_W-1:0] palette [5] = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};
        case (style)
            PIX_EXTREME: return palette[$urandom_range(4)];
            PIX_NARROW:  return PIX_W'($urandom_range(100, 104));
            default:     return PIX_W'($urandom);
        endcase
    endfunction

    task automatic push_frame(int n, t_pix_style style);
        t_rgb p;
        for (int i = 0; i < n; i++) begin
            p.r = pick_chan(style);
            p.g = pick_chan(style);
            p.b = pick_chan(style);
            pix_q.push_back(p);
        end
    endtask

    // Block quiet: nothing queued or offered, nothing expected, and the pipe
    // given time to flush pixels that produce no result
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pix_q.size() != 0 || in_valid || median_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only with the block quiet; a write restarts the frame
    task automatic write_frame_reg(rgbmf_pkg::t_cfg_index idx, logic [CFG_W-1:0] val);
        wait_idle();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == rgbmf_pkg::CFG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_idle(int send_pct, int stall_pct);
        sender_idle    <= send_pct;
        receiver_stall <= stall_pct;
    endtask

    // Mostly small frames; now and then a wider one, kept short enough that
    // the item count stays near its target
    function automatic logic [CFG_W-1:0] pick_size(int hi);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return CFG_W'($urandom_range(2));        // clamped up to 3
        if (roll < 20 && hi > 20) return CFG_W'($urandom_range(25, 40));
        return CFG_W'($urandom_range(MIN_SIZE, (hi > 20) ? 24 : hi));
    endfunction

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        t_rgb p;
        int   area;
        int   phase_items;
        int   which;
        @(posedge i_rst_n);

        // Short run at the reset frame size, cut off by the next write
        push_frame(40, PIX_RANDOM);

        // Smallest frame, reached through clamping of sizes below range
        write_frame_reg(rgbmf_pkg::CFG_IMAGE_WIDTH, '0);
        write_frame_reg(rgbmf_pkg::CFG_IMAGE_HEIGHT, CFG_W'(2));
        for (int i = 0; i < 9; i++) begin
            p.r = (i % 2 == 1 || i == 8) ? 8'hFF : 8'h00;
            p.g = PIX_W'(i * 31);
            p.b = PIX_W'(255 - i * 31);
            pix_q.push_back(p);
        end
        push_frame(9, PIX_EXTREME);
        // Broken frame: a write part way through must restart at (0,0)
        push_frame(4, PIX_RANDOM);
        write_frame_reg(rgbmf_pkg::CFG_IMAGE_HEIGHT, CFG_W'(1));
        // Full frame plus one item that opens the next frame
        push_frame(10, PIX_EXTREME);

        // Height register all ones (clamped), narrowest width: top rows only
        write_frame_reg(rgbmf_pkg::CFG_IMAGE_HEIGHT, '1);
        push_frame(30, PIX_EXTREME);

        // Back-pressure: output held off while the driver keeps offering
        write_frame_reg(rgbmf_pkg::CFG_IMAGE_WIDTH, CFG_W'(8));
        write_frame_reg(rgbmf_pkg::CFG_IMAGE_HEIGHT, CFG_W'(30));
        push_frame(240, PIX_RANDOM);
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;

        // Random frames under each idle mix
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0:       set_idle(0, 0);
                1:       set_idle(66, 0);
                2:       set_idle(0, 66);
                default: set_idle(29, 29);
            endcase
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / NUM_PHASES) begin
                which = $urandom_range(3);
                if (which != 2) begin
                    write_frame_reg(rgbmf_pkg::CFG_IMAGE_WIDTH, pick_size(STORE_DEPTH));
                end
                if (which != 1) begin
                    write_frame_reg(rgbmf_pkg::CFG_IMAGE_HEIGHT, pick_size(10));
                end
                area = eff_size(width_reg, STORE_DEPTH) * eff_size(height_reg, MAX_HEIGHT);
                for (int f = $urandom_range(1, 2); f > 0; f--) begin
                    push_frame(area, t_pix_style'($urandom_range(2)));
                    phase_items += area;
                end
                // Now and then leave a frame unfinished before the next write
                if ($urandom_range(9) < 3) begin
                    which = $urandom_range(1, area - 1);
                    push_frame(which, PIX_RANDOM);
                    phase_items += which;
                end
            end
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("tb_rgb_median_filter_3x3_top passed");
        end else begin
            $display("tb_rgb_median_filter_3x3_top failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("tb_rgb_median_filter_3x3_top failed");
        $finish;
    end

endmodule

/* rgb_median_filter_3x3_top.f */
src/rgbmf_pkg.sv
src/rgbmf_line_ram.sv
src/rgbmf_med9.sv
src/rgbmf_out_skid.sv
src/rgb_median_filter_3x3_top.sv
tb/tb_rgb_median_filter_3x3_top.sv
